/* rtl/nearest_palette_color_unit_defines.svh */
// Assertion macros for the nearest palette colour unit.
// Clocked on clk_i; NPC_ASSERT is disabled while rst_ni is low, NPC_ASSERT_RST is not; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define NPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define NPC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define NPC_ASSERT(lbl, prop, msg)
`define NPC_ASSERT_RST(lbl, prop, msg)
`endif

`endif

/* rtl/npc_pkg.sv */
// Shared types, constants and the VGA palette ROM for the nearest palette colour unit.
// No dependencies.
`default_nettype none

package npc_pkg;

  localparam int unsigned ROM_SIZE  = 256;
  localparam int unsigned ROM_IDX_W = 8;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SQ_W      = 2 * CHAN_W;
  localparam int unsigned DIST_W    = SQ_W + 2;
  // one above the largest reachable distance, 3*255*255+1
  localparam logic [DIST_W-1:0] DIST_START = 18'd195076;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } npc_state_e;

  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [ROM_IDX_W-1:0] idx;
    logic [DIST_W-1:0]    sq_dist;
  } npc_dist_t;

  typedef struct packed {
    logic                 done;
    logic [ROM_IDX_W-1:0] pick;
  } npc_best_t;

  localparam logic [23:0] VGA_ROM [ROM_SIZE] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
    24'h000000, 24'h101010, 24'h202020, 24'h353535, 24'h454545, 24'h555555, 24'h656565, 24'h757575,
    24'h8A8A8A, 24'h9A9A9A, 24'hAAAAAA, 24'hBABABA, 24'hCACACA, 24'hDFDFDF, 24'hEFEFEF, 24'hFFFFFF,
    24'h0000FF, 24'h4100FF, 24'h8200FF, 24'hBE00FF, 24'hFF00FF, 24'hFF00BE, 24'hFF0082, 24'hFF0041,
    24'hFF0000, 24'hFF4100, 24'hFF8200, 24'hFFBE00, 24'hFFFF00, 24'hBEFF00, 24'h82FF00, 24'h41FF00,
    24'h00FF00, 24'h00FF41, 24'h00FF82, 24'h00FFBE, 24'h00FFFF, 24'h00BEFF, 24'h0082FF, 24'h0041FF,
    24'h8282FF, 24'h9E82FF, 24'hBE82FF, 24'hDF82FF, 24'hFF82FF, 24'hFF82DF, 24'hFF82BE, 24'hFF829E,
    24'hFF8282, 24'hFF9E82, 24'hFFBE82, 24'hFFDF82, 24'hFFFF82, 24'hDFFF82, 24'hBEFF82, 24'h9EFF82,
    24'h82FF82, 24'h82FF9E, 24'h82FFBE, 24'h82FFDF, 24'h82FFFF, 24'h82DFFF, 24'h82BEFF, 24'h829EFF,
    24'hBABAFF, 24'hCABAFF, 24'hDFBAFF, 24'hEFBAFF, 24'hFFBAFF, 24'hFFBAEF, 24'hFFBADF, 24'hFFBACA,
    24'hFFBABA, 24'hFFCABA, 24'hFFDFBA, 24'hFFEFBA, 24'hFFFFBA, 24'hEFFFBA, 24'hDFFFBA, 24'hCAFFBA,
    24'hBAFFBA, 24'hBAFFCA, 24'hBAFFDF, 24'hBAFFEF, 24'hBAFFFF, 24'hBAEFFF, 24'hBADFFF, 24'hBACAFF,
    24'h000071, 24'h1C0071, 24'h390071, 24'h550071, 24'h710071, 24'h710055, 24'h710039, 24'h71001C,
    24'h710000, 24'h711C00, 24'h713900, 24'h715500, 24'h717100, 24'h557100, 24'h397100, 24'h1C7100,
    24'h007100, 24'h00711C, 24'h007139, 24'h007155, 24'h007171, 24'h005571, 24'h003971, 24'h001C71,
    24'h393971, 24'h453971, 24'h553971, 24'h613971, 24'h713971, 24'h713961, 24'h713955, 24'h713945,
    24'h713939, 24'h714539, 24'h715539, 24'h716139, 24'h717139, 24'h617139, 24'h557139, 24'h457139,
    24'h397139, 24'h397145, 24'h397155, 24'h397161, 24'h397171, 24'h396171, 24'h395571, 24'h394571,
    24'h515171, 24'h595171, 24'h615171, 24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
    24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151, 24'h697151, 24'h617151, 24'h597151,
    24'h517151, 24'h517159, 24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171, 24'h515971,
    24'h000041, 24'h100041, 24'h200041, 24'h310041, 24'h410041, 24'h410031, 24'h410020, 24'h410010,
    24'h410000, 24'h411000, 24'h412000, 24'h413100, 24'h414100, 24'h314100, 24'h204100, 24'h104100,
    24'h004100, 24'h004110, 24'h004120, 24'h004131, 24'h004141, 24'h003141, 24'h002041, 24'h001041,
    24'h202041, 24'h282041, 24'h312041, 24'h392041, 24'h412041, 24'h412039, 24'h412031, 24'h412028,
    24'h412020, 24'h412820, 24'h413120, 24'h413920, 24'h414120, 24'h394120, 24'h314120, 24'h284120,
    24'h204120, 24'h204128, 24'h204131, 24'h204139, 24'h204141, 24'h203941, 24'h203141, 24'h202841,
    24'h2D2D41, 24'h312D41, 24'h352D41, 24'h3D2D41, 24'h412D41, 24'h412D3D, 24'h412D35, 24'h412D31,
    24'h412D2D, 24'h41312D, 24'h41352D, 24'h413D2D, 24'h41412D, 24'h3D412D, 24'h35412D, 24'h31412D,
    24'h2D412D, 24'h2D4131, 24'h2D4135, 24'h2D413D, 24'h2D4141, 24'h2D3D41, 24'h2D3541, 24'h2D3141,
    24'h0055AA, 24'hAA0055, 24'hAA5555, 24'hAAAA55, 24'hFF5500, 24'hFF55AA, 24'hFFAA00, 24'hFFAA55
  };

endpackage

`default_nettype wire

/* rtl/npc_dist.sv */
// Distance unit: reads one palette entry and forms the squared RGB distance to the pixel.
// Depends on npc_pkg (ROM, widths, npc_dist_t). Result is registered.
`default_nettype none

module npc_dist
  import npc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 issue_i,
  input  wire logic                 last_i,
  input  wire logic [ROM_IDX_W-1:0] idx_i,
  input  wire logic [23:0]          pixel_i,
  output npc_dist_t                 dist_o
);

  logic [23:0]        entry;
  logic [CHAN_W-1:0]  diff_r, diff_g, diff_b;
  logic [SQ_W-1:0]    sq_r, sq_g, sq_b;
  logic [DIST_W-1:0]  dist_sum;
  logic               valid_q;
  logic               last_q;
  logic [ROM_IDX_W-1:0] idx_q;
  logic [DIST_W-1:0]  dist_q;

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    entry  = VGA_ROM[idx_i];
    diff_r = abs_diff(entry[23:16], pixel_i[23:16]);
    diff_g = abs_diff(entry[15:8],  pixel_i[15:8]);
    diff_b = abs_diff(entry[7:0],   pixel_i[7:0]);
    sq_r   = SQ_W'(diff_r) * SQ_W'(diff_r);
    sq_g   = SQ_W'(diff_g) * SQ_W'(diff_g);
    sq_b   = SQ_W'(diff_b) * SQ_W'(diff_b);
    dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      last_q <= last_i;
      idx_q  <= idx_i;
      dist_q <= dist_sum;
    end
  end

  assign dist_o.valid   = valid_q;
  assign dist_o.last    = last_q;
  assign dist_o.idx     = idx_q;
  assign dist_o.sq_dist = dist_q;

endmodule

`default_nettype wire

/* rtl/npc_best.sv */
// Best-match tracker: keeps the smallest distance seen and the index it came from.
// Depends on npc_pkg (npc_dist_t, npc_best_t, DIST_START).
`default_nettype none

module npc_best
  import npc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire npc_dist_t dist_i,
  output npc_best_t      best_o
);

  logic [DIST_W-1:0]    best_q, best_d;
  logic [ROM_IDX_W-1:0] pick_q, pick_d;
  logic                 stop_q, stop_d;
  logic                 done_q, done_d;

  always_comb begin
    best_d = best_q;
    pick_d = pick_q;
    stop_d = stop_q;
    done_d = done_q;
    if (start_i) begin
      best_d = DIST_START;
      pick_d = '0;
      stop_d = 1'b0;
      done_d = 1'b0;
    end else if (dist_i.valid) begin
      if (!stop_q) begin
        if (dist_i.sq_dist < best_q) begin
          best_d = dist_i.sq_dist;
          pick_d = dist_i.idx;
        end else if (dist_i.sq_dist == '0) begin
          // second exact match wins and freezes the pick
          pick_d = dist_i.idx;
          stop_d = 1'b1;
        end
      end
      if (dist_i.last) begin
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      stop_q <= stop_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q <= best_d;
    pick_q <= pick_d;
  end

  assign best_o.done = done_q;
  assign best_o.pick = pick_q;

endmodule

`default_nettype wire

/* rtl/nearest_palette_color_unit.sv */
// Nearest palette colour unit, top level: sequencer, pixel register and output word register.
// Depends on npc_pkg, npc_dist, npc_best and nearest_palette_color_unit_defines.svh.
//
// Use:
//   One input word per pixel on in_valid_i/in_ready_o with pixel_rgb_i (R 23:16, G 15:8,
//   B 7:0); one output word per pixel on out_valid_o/out_ready_i with palette_index_o.
//   The sequencer steps a shared distance unit over the palette, one entry per cycle from
//   index 0 up, and a tracker keeps the best match (strictly smaller wins; a second exact
//   match is taken and freezes the result).
// Sequence:
//   After a pixel is accepted, each entry in turn passes through the distance unit and its
//   result register and then the tracker; the final pick is loaded into the output
//   register. in_ready_o is high again once the sequencer is back in idle, so a new pixel
//   is taken only after the scan of the previous one is through.
// Reset and stalls:
//   Reset returns the sequencer to idle and empties the output register. A result that is
//   not taken stays in the output register; a further pixel is accepted and scanned
//   meanwhile, and its result waits in the tracker until the output register is free.
`default_nettype none

`include "nearest_palette_color_unit_defines.svh"

module nearest_palette_color_unit
  import npc_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [23:0] pixel_rgb_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       palette_index_o
);

  localparam int unsigned IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [7:0]       LAST_PICK = 8'(PALETTE_ENTRIES - 1);

  npc_state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [23:0]      pixel_q;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       index_q;

  logic      accept;
  logic      issue;
  logic      issue_last;
  logic      load_out;
  npc_dist_t dist_res;
  npc_best_t best_res;

  assign accept     = in_valid_i && in_ready_o;
  assign issue_last = (idx_q == LAST_IDX);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (issue_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (best_res.done && (!out_valid_q || out_ready_i)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    issue      = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_SCAN:  issue      = 1'b1;
      ST_DRAIN: load_out   = best_res.done && (!out_valid_q || out_ready_i);
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    if (accept) begin
      idx_d = '0;
    end else if (issue && !issue_last) begin
      idx_d = idx_q + 1'b1;
    end
  end

  assign out_valid_d = load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pixel_q <= pixel_rgb_i;
    if (load_out) index_q <= best_res.pick;
  end

  npc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .last_i  (issue_last),
    .idx_i   (ROM_IDX_W'(idx_q)),
    .pixel_i (pixel_q),
    .dist_o  (dist_res)
  );

  npc_best u_best (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .dist_i  (dist_res),
    .best_o  (best_res)
  );

  assign out_valid_o     = out_valid_q;
  assign palette_index_o = index_q;

  `NPC_ASSERT(a_accept_starts_scan, accept |=> (state_q == ST_SCAN) && (idx_q == '0),
              "accepted pixel did not start a scan at entry 0")
  `NPC_ASSERT(a_dist_only_busy, dist_res.valid |-> (state_q != ST_IDLE),
              "distance word produced while sequencer idle")
  `NPC_ASSERT(a_index_in_range, out_valid_o |-> (palette_index_o <= LAST_PICK),
              "palette index beyond scanned entries")
  `NPC_ASSERT(a_load_after_done, load_out |-> best_res.done && !dist_res.valid,
              "output loaded before the scan finished")

endmodule

`default_nettype wire
